[src/sgm_pkg.sv]
// Shared types, constants and helper functions for the Sobel gradient magnitude core.
// Used by every module in src; no dependencies of its own.
`default_nettype none

package sgm_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int PIX_W       = 8;
  localparam int CFG_W_W     = 11;
  localparam int CFG_H_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 16'd480;
  localparam logic [CFG_W_W-1:0] WIDTH_MIN    = 11'd3;
  localparam logic [CFG_H_W-1:0] HEIGHT_MIN   = 16'd3;

  // arithmetic widths of the back end
  localparam int SUM3_W = 10;   // tl + 2*ml + bl, at most 1020
  localparam int GRAD_W = 11;   // signed gradient
  localparam int SQ_W   = 20;   // gradient squared
  localparam int SUM_W  = 21;   // gx^2 + gy^2
  localparam int SQRT_W = 22;   // working width of the root iteration
  localparam int ROOT_W = 11;
  localparam int SQRT_STEPS = 11;
  localparam int QUOT_W = 21;

  // floor(r/3) == (r*683) >> 11 for every r below 2048
  localparam logic [9:0] DIV3_RECIP = 10'd683;
  localparam int         DIV3_SHIFT = 11;
  localparam logic [7:0] MAG_MAX    = 8'd255;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  magnitude;
    logic [9:0]  out_x;
    logic [15:0] out_y;
    logic        frame_end;
  } mag_out_t;

  typedef struct packed {
    logic [9:0]  out_x;
    logic [15:0] out_y;
    logic        frame_end;
  } coord_t;

  typedef struct packed {
    logic [7:0] tl;
    logic [7:0] ml;
    logic [7:0] bl;
    logic [7:0] tm;
    logic [7:0] bm;
    logic [7:0] tr;
    logic [7:0] mr;
    logic [7:0] br;
    coord_t     pos;
  } win_item_t;

  typedef struct packed {
    logic [SQRT_W-1:0] rem;
    logic [SQRT_W-1:0] root;
  } sqrt_st_t;

  // one digit of the bit-by-bit floor square root; trial bit is 1 << sh
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [4:0] sh);
    logic [SQRT_W-1:0] trial_bit;
    logic [SQRT_W-1:0] trial;
    sqrt_st_t          r;
    trial_bit = SQRT_W'(1) << sh;
    trial     = s.root + trial_bit;
    if (s.rem >= trial) begin
      r.rem  = s.rem - trial;
      r.root = (s.root >> 1) + trial_bit;
    end else begin
      r.rem  = s.rem;
      r.root = s.root >> 1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/sgm_front.sv]
// Front end: raster counters, two line stores, 3x3 window; pushes full windows.
// Depends on sgm_pkg.
`default_nettype none

module sgm_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [sgm_pkg::CFG_W_W-1:0] image_width,
  input  wire logic [sgm_pkg::CFG_H_W-1:0] image_height,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire sgm_pkg::pix_in_t            in_data,
  output logic                             q_push,
  output sgm_pkg::win_item_t               q_push_data,
  input  wire logic                        q_full
);

  localparam int COL_W = sgm_pkg::COL_W;
  localparam int WW    = sgm_pkg::CFG_W_W;
  localparam int HW    = sgm_pkg::CFG_H_W;

  logic [7:0] upper_mem_r  [sgm_pkg::MAX_WIDTH];
  logic [7:0] middle_mem_r [sgm_pkg::MAX_WIDTH];
  logic [7:0] win_r [6];

  logic [COL_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [HW-1:0]    row_cnt_r, row_cnt_nxt;

  logic             s1_valid_r;
  logic [7:0]       s1_pix_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_emit_r;
  sgm_pkg::coord_t  s1_pos_r;

  logic [7:0] upper_rd_r, middle_rd_r;
  logic       byp_r;
  logic [7:0] byp_top_r, byp_mid_r;

  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [COL_W-1:0] cur_col;
  logic [HW:0]      cur_row;
  logic [WW-1:0]    col_inc;
  logic [HW:0]      row_inc;
  logic             accept;
  logic             s1_fire;
  logic             cur_emit;
  sgm_pkg::coord_t  cur_pos;
  logic [7:0]       top_eff, mid_eff;

  // effective frame size and position of the incoming pixel
  always_comb begin
    w_eff = image_width;
    if (image_width < sgm_pkg::WIDTH_MIN) begin
      w_eff = sgm_pkg::WIDTH_MIN;
    end else if (32'(image_width) > sgm_pkg::MAX_WIDTH) begin
      w_eff = WW'(sgm_pkg::MAX_WIDTH);
    end
    h_eff = (image_height < sgm_pkg::HEIGHT_MIN) ? sgm_pkg::HEIGHT_MIN : image_height;

    cur_col = in_data.frame_start ? '0 : col_cnt_r;
    cur_row = in_data.frame_start ? '0 : {1'b0, row_cnt_r};
    // width shrunk since the last pixel: start a new row
    if (WW'(cur_col) >= w_eff) begin
      cur_col = '0;
      cur_row = cur_row + 1'b1;
    end
    if (cur_row >= {1'b0, h_eff}) begin
      cur_row = '0;
    end

    col_inc = WW'(cur_col) + 1'b1;
    row_inc = cur_row + 1'b1;
    if (col_inc >= w_eff) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[HW-1:0];
    end else begin
      col_cnt_nxt = col_inc[COL_W-1:0];
      row_cnt_nxt = cur_row[HW-1:0];
    end

    cur_emit          = (cur_col >= COL_W'(2)) && (cur_row >= (HW+1)'(2));
    cur_pos.out_x     = 10'(cur_col - COL_W'(2));
    cur_pos.out_y     = cur_row[HW-1:0] - HW'(2);
    cur_pos.frame_end = (WW'(cur_col) == w_eff - 1'b1) && (cur_row[HW-1:0] == h_eff - 1'b1);
  end

  assign s1_fire  = s1_valid_r && (!s1_emit_r || !q_full);
  assign in_ready = !s1_valid_r || s1_fire;
  assign accept   = in_valid && in_ready;

  // a read in the same cycle as a write to that column sees the new data
  assign top_eff = byp_r ? byp_top_r : upper_rd_r;
  assign mid_eff = byp_r ? byp_mid_r : middle_rd_r;

  always_comb begin
    q_push               = s1_fire && s1_emit_r;
    q_push_data.tl       = win_r[0];
    q_push_data.ml       = win_r[1];
    q_push_data.bl       = win_r[2];
    q_push_data.tm       = win_r[3];
    q_push_data.bm       = win_r[5];
    q_push_data.tr       = top_eff;
    q_push_data.mr       = mid_eff;
    q_push_data.br       = s1_pix_r;
    q_push_data.pos      = s1_pos_r;
  end

  // line stores
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      upper_mem_r[s1_col_r]  <= mid_eff;
      middle_mem_r[s1_col_r] <= s1_pix_r;
    end
    if (accept) begin
      upper_rd_r  <= upper_mem_r[cur_col];
      middle_rd_r <= middle_mem_r[cur_col];
      byp_top_r   <= mid_eff;
      byp_mid_r   <= s1_pix_r;
      s1_pix_r    <= in_data.pixel;
      s1_col_r    <= cur_col;
      s1_emit_r   <= cur_emit;
      s1_pos_r    <= cur_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
      byp_r      <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (accept) begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
        byp_r     <= s1_valid_r && (s1_col_r == cur_col);
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= top_eff;
        win_r[4] <= mid_eff;
        win_r[5] <= s1_pix_r;
      end
    end
  end

`ifndef SYNTHESIS
  a_stall_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |-> (s1_emit_r && q_full))
    else $error("front stage stalled without a full queue");

  a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r)
    else $error("input blocked with an empty front stage");
`endif

endmodule

`default_nettype wire

[src/sgm_queue.sv]
// Small FIFO between the front end and the arithmetic back end.
// Depends on sgm_pkg.
`default_nettype none

module sgm_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire sgm_pkg::win_item_t push_data,
  output logic                    full,
  input  wire logic               pop,
  output sgm_pkg::win_item_t      pop_data,
  output logic                    empty
);

  localparam int PW = sgm_pkg::QPTR_W;
  localparam int DEPTH = sgm_pkg::QUEUE_DEPTH;

  sgm_pkg::win_item_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign full     = (count_r == (PW+1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue underflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PW+1)'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

[src/sgm_back.sv]
// Back end: Sobel sums, squares, pipelined floor square root, divide by 3, clamp.
// Depends on sgm_pkg.
`default_nettype none

module sgm_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire sgm_pkg::win_item_t q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output sgm_pkg::mag_out_t       out_data
);

  localparam int GW = sgm_pkg::GRAD_W;
  localparam int S3 = sgm_pkg::SUM3_W;

  logic adv;

  // stage 1: gradients
  logic                 g_valid_r;
  logic signed [GW-1:0] gx_r, gy_r;
  sgm_pkg::coord_t      g_pos_r;
  // stage 2: squares
  logic                       p_valid_r;
  logic [sgm_pkg::SQ_W-1:0]   sqx_r, sqy_r;
  sgm_pkg::coord_t            p_pos_r;
  // stage 3: sum of squares
  logic                       s_valid_r;
  logic [sgm_pkg::SUM_W-1:0]  sum_r;
  sgm_pkg::coord_t            s_pos_r;
  // stages 4..6: root digits
  logic             r_valid_r [3];
  sgm_pkg::sqrt_st_t r_st_r   [3];
  sgm_pkg::coord_t  r_pos_r   [3];
  // output register
  logic             out_valid_r;
  sgm_pkg::mag_out_t out_r;

  logic [S3-1:0]           lsum, rsum, tsum, bsum;
  logic signed [GW-1:0]    gx, gy;
  logic signed [2*GW-1:0]  px, py;
  sgm_pkg::sqrt_st_t       st_in  [3];
  sgm_pkg::sqrt_st_t       st_out [3];
  logic [sgm_pkg::QUOT_W-1:0] quot;
  logic [sgm_pkg::QUOT_W-sgm_pkg::DIV3_SHIFT-1:0] q_hi;
  logic [7:0]              mag;

  assign adv       = !out_valid_r || out_ready;
  assign q_pop     = adv && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    lsum = S3'(q_data.tl) + {1'b0, q_data.ml, 1'b0} + S3'(q_data.bl);
    rsum = S3'(q_data.tr) + {1'b0, q_data.mr, 1'b0} + S3'(q_data.br);
    tsum = S3'(q_data.tl) + {1'b0, q_data.tm, 1'b0} + S3'(q_data.tr);
    bsum = S3'(q_data.bl) + {1'b0, q_data.bm, 1'b0} + S3'(q_data.br);
    gx   = $signed({1'b0, lsum}) - $signed({1'b0, rsum});
    gy   = $signed({1'b0, tsum}) - $signed({1'b0, bsum});
    px   = gx_r * gx_r;
    py   = gy_r * gy_r;
  end

  // root digits: stage 0 takes digits 0..3, stage 1 4..7, stage 2 8..10
  always_comb begin
    st_in[0].rem  = sgm_pkg::SQRT_W'(sum_r);
    st_in[0].root = '0;
    st_in[1]      = r_st_r[0];
    st_in[2]      = r_st_r[1];
    for (int s = 0; s < 3; s++) begin
      st_out[s] = st_in[s];
      for (int d = 0; d < 4; d++) begin
        if (s * 4 + d < sgm_pkg::SQRT_STEPS) begin
          st_out[s] = sgm_pkg::sqrt_step(st_out[s], 5'(20 - 2 * (s * 4 + d)));
        end
      end
    end
  end

  always_comb begin
    quot = r_st_r[2].root[sgm_pkg::ROOT_W-1:0] * sgm_pkg::DIV3_RECIP;
    q_hi = quot[sgm_pkg::QUOT_W-1:sgm_pkg::DIV3_SHIFT];
    mag  = (q_hi > 10'(sgm_pkg::MAG_MAX)) ? sgm_pkg::MAG_MAX : q_hi[7:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gx_r    <= gx;
      gy_r    <= gy;
      g_pos_r <= q_data.pos;
      sqx_r   <= px[sgm_pkg::SQ_W-1:0];
      sqy_r   <= py[sgm_pkg::SQ_W-1:0];
      p_pos_r <= g_pos_r;
      sum_r   <= sgm_pkg::SUM_W'(sqx_r) + sgm_pkg::SUM_W'(sqy_r);
      s_pos_r <= p_pos_r;
      r_pos_r[0] <= s_pos_r;
      r_pos_r[1] <= r_pos_r[0];
      r_pos_r[2] <= r_pos_r[1];
      for (int s = 0; s < 3; s++) begin
        r_st_r[s] <= st_out[s];
      end
      out_r.magnitude <= mag;
      out_r.out_x     <= r_pos_r[2].out_x;
      out_r.out_y     <= r_pos_r[2].out_y;
      out_r.frame_end <= r_pos_r[2].frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r   <= 1'b0;
      p_valid_r   <= 1'b0;
      s_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < 3; s++) begin
        r_valid_r[s] <= 1'b0;
      end
    end else if (adv) begin
      g_valid_r    <= !q_empty;
      p_valid_r    <= g_valid_r;
      s_valid_r    <= p_valid_r;
      r_valid_r[0] <= s_valid_r;
      r_valid_r[1] <= r_valid_r[0];
      r_valid_r[2] <= r_valid_r[1];
      out_valid_r  <= r_valid_r[2];
    end
  end

endmodule

`default_nettype wire

[src/sobel_gradient_magnitude_core.sv]
// Sobel 3x3 gradient magnitude core: one pixel per clock in, one result per interior pixel.
// Input is held (in_ready low) while the window queue is full and a window is waiting.
// Throughput: 1 pixel per cycle, set by the line-store port (one read, one write per cycle).
// Reset (rst_n low, synchronous): counters to row 0 / column 0, window cleared,
// width 640, height 480; line store contents are left as they are.
`default_nettype none

module sobel_gradient_magnitude_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire sgm_pkg::pix_in_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output sgm_pkg::mag_out_t                   out_data,
  input  wire logic                           cfg_we,
  input  wire sgm_pkg::cfg_idx_t              cfg_index,
  input  wire logic [sgm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [sgm_pkg::CFG_W_W-1:0] image_width_r;
  logic [sgm_pkg::CFG_H_W-1:0] image_height_r;

  logic               q_push, q_full, q_pop, q_empty;
  sgm_pkg::win_item_t q_push_data, q_pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= sgm_pkg::WIDTH_RESET;
      image_height_r <= sgm_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        sgm_pkg::CFG_IMAGE_WIDTH: begin
          image_width_r <= cfg_wdata[sgm_pkg::CFG_W_W-1:0];
        end
        sgm_pkg::CFG_IMAGE_HEIGHT: begin
          image_height_r <= cfg_wdata[sgm_pkg::CFG_H_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  sgm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .q_push       (q_push),
    .q_push_data  (q_push_data),
    .q_full       (q_full)
  );

  sgm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  sgm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
